// File: rtl/bmf_pkg.sv
// Package for the box mean filter: item types, register indexes and store sizes.
// No dependencies; used by box_mean_filter.
package bmf_pkg;

    // frame limits: the radius by its 3-bit register, the width by a clamp in the filter
    localparam int MaxWidth   = 1024;
    localparam int MaxRadius  = 7;
    localparam int LineDepth  = (2 * MaxRadius + 2) * MaxWidth;
    localparam int LineAddrW  = $clog2(LineDepth);
    localparam int PosW       = 23;

    // register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;

    // item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] mean_value;
        logic       last_of_frame;
    } out_item_t;

endpackage

// File: rtl/box_mean_filter.sv
// Box mean filter over a clipped (2r+1)-square window, pixels in raster order.
// Each result is formed by a 23-step shared divider, used twice, and by one line
// store read per window pixel.
// Items are taken one at a time; in_stall holds the next until the last is done.
// Reset: control, positions and registers (640 x 480, radius 1) cleared at once;
// the line store is not reset.
module box_mean_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bmf_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bmf_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data
);

    localparam int AW = bmf_pkg::LineAddrW;
    localparam int PW = bmf_pkg::PosW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_ACC    = 4'd2;
    localparam logic [3:0] S_DIVK   = 4'd3;
    localparam logic [3:0] S_BOUND  = 4'd4;
    localparam logic [3:0] S_BASE   = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_SUMEND = 4'd7;
    localparam logic [3:0] S_MLOAD  = 4'd8;
    localparam logic [3:0] S_DIVM   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    // configuration registers
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            radius_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bmf_pkg::CFG_IMAGE_WIDTH)
                width_reg <= cfg_data[10:0];
            else if (cfg_index == bmf_pkg::CFG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
            else if (cfg_index == bmf_pkg::CFG_WINDOW_RADIUS)
                radius_reg <= cfg_data[2:0];
        end
    end

    // effective frame geometry
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    always_comb
    begin
        if (width_reg == 11'd0)
            w_eff = 11'd1;
        else if (width_reg > 11'(bmf_pkg::MaxWidth))
            w_eff = 11'(bmf_pkg::MaxWidth);
        else
            w_eff = width_reg;
        h_eff = (height_reg == 13'd0) ? 13'd1 : height_reg;
    end

    // frame size and release distance, registered
    logic [PW-1:0] n_reg;
    logic [13:0]   d_reg;
    always_ff @(posedge clk)
    begin
        n_reg <= PW'(w_eff * h_eff);
        d_reg <= 14'(radius_reg * w_eff) + 14'(radius_reg);
    end

    // control and datapath registers
    logic [3:0]           state_reg, state_next;
    logic [PW-1:0]        ip_reg, ip_next;
    logic [PW-1:0]        op_reg, op_next;
    bmf_pkg::in_item_t    item_reg, item_next;
    logic [PW-1:0]        dq_reg, dq_next;
    logic [10:0]          drem_reg, drem_next;
    logic [10:0]          dd_reg, dd_next;
    logic [4:0]           dcnt_reg, dcnt_next;
    logic [12:0]          r0_reg, r0_next;
    logic [3:0]           rows_reg, rows_next;
    logic [10:0]          c0_reg, c0_next;
    logic [10:0]          c1_reg, c1_next;
    logic [10:0]          col_reg, col_next;
    logic [7:0]           count_reg, count_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [15:0]          sum_reg, sum_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    bmf_pkg::out_item_t   out_reg, out_next;

    // line store
    logic [7:0]    line_mem [bmf_pkg::LineDepth];
    logic [7:0]    rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_waddr] <= item_reg.pixel;
        rd_data <= line_mem[mem_raddr];
    end

    // step of the shared restoring divider
    logic [11:0] rem_sh;
    logic [11:0] rem_try;
    assign rem_sh  = {drem_reg, dq_reg[PW-1]};
    assign rem_try = rem_sh - {1'b0, dd_reg};

    // item step and window bounds helpers
    logic          restart;
    logic [PW-1:0] ip_v, op_v, ip_inc;
    logic          drop, result;
    logic [12:0]   i_v;
    logic [10:0]   j_v;
    logic [13:0]   i_hi;
    logic [11:0]   j_hi;
    logic [12:0]   r0_v, r1_v;
    logic [10:0]   c0_v, c1_v;
    logic [PW-1:0] op_inc;

    always_comb
    begin
        restart = (op_reg >= n_reg);
        ip_v    = restart ? '0 : ip_reg;
        op_v    = restart ? '0 : op_reg;
        drop    = (item_reg.opcode == bmf_pkg::OP_DRAIN) && (ip_v < n_reg);
        ip_inc  = (ip_v < n_reg + PW'(d_reg)) ? ip_v + 1'b1 : ip_v;
        result  = !drop && (op_v + PW'(d_reg) < ip_inc);

        i_v  = dq_reg[12:0];
        j_v  = drem_reg;
        i_hi = {1'b0, i_v} + 14'(radius_reg);
        j_hi = {1'b0, j_v} + 12'(radius_reg);
        r0_v = (i_v >= 13'(radius_reg)) ? i_v - 13'(radius_reg) : 13'd0;
        r1_v = (i_hi < {1'b0, h_eff - 13'd1}) ? i_hi[12:0] : h_eff - 13'd1;
        c0_v = (j_v >= 11'(radius_reg)) ? j_v - 11'(radius_reg) : 11'd0;
        c1_v = (j_hi < {1'b0, w_eff - 11'd1}) ? j_hi[10:0] : w_eff - 11'd1;
        op_inc = op_reg + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        ip_next        = ip_reg;
        op_next        = op_reg;
        item_next      = item_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        dd_next        = dd_reg;
        dcnt_next      = dcnt_reg;
        r0_next        = r0_reg;
        rows_next      = rows_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        col_next       = col_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        sum_next       = pend_reg ? sum_reg + 16'(rd_data) : sum_reg;
        pend_next      = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = ip_v[AW-1:0];
        mem_raddr      = base_reg + AW'(col_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_PREP;
                end
            end
            S_PREP:
                state_next = S_ACC;
            S_ACC:
            begin
                mem_we  = (item_reg.opcode == bmf_pkg::OP_PIXEL) && (ip_v < n_reg);
                ip_next = drop ? ip_v : ip_inc;
                op_next = op_v;
                if (result)
                begin
                    dq_next    = op_v;
                    drem_next  = '0;
                    dd_next    = w_eff;
                    dcnt_next  = 5'(PW - 1);
                    state_next = S_DIVK;
                end
                else
                    state_next = S_IDLE;
            end
            S_DIVK, S_DIVM:
            begin
                if (rem_sh >= {1'b0, dd_reg})
                begin
                    drem_next = rem_try[10:0];
                    dq_next   = {dq_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    drem_next = rem_sh[10:0];
                    dq_next   = {dq_reg[PW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0)
                    state_next = (state_reg == S_DIVK) ? S_BOUND : S_OUT;
            end
            S_BOUND:
            begin
                r0_next    = r0_v;
                rows_next  = 4'(r1_v - r0_v) + 4'd1;
                c0_next    = c0_v;
                c1_next    = c1_v;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                base_next  = AW'(r0_reg * w_eff);
                count_next = 8'(rows_reg * (4'(c1_reg - c0_reg) + 4'd1));
                col_next   = c0_reg;
                sum_next   = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                pend_next = 1'b1;
                if (col_reg == c1_reg)
                begin
                    col_next  = c0_reg;
                    base_next = base_reg + AW'(w_eff);
                    rows_next = rows_reg - 4'd1;
                    if (rows_reg == 4'd1)
                        state_next = S_SUMEND;
                end
                else
                    col_next = col_reg + 11'd1;
            end
            S_SUMEND:
                state_next = S_MLOAD;
            S_MLOAD:
            begin
                dq_next    = PW'(sum_reg);
                drem_next  = '0;
                dd_next    = 11'(count_reg);
                dcnt_next  = 5'(PW - 1);
                state_next = S_DIVM;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_next.mean_value    = dq_reg[7:0];
                    out_next.last_of_frame = (op_inc == n_reg);
                    if (op_inc == n_reg)
                    begin
                        ip_next = '0;
                        op_next = '0;
                    end
                    else
                        op_next = op_inc;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ip_reg        <= '0;
            op_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ip_reg        <= ip_next;
            op_reg        <= op_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        dq_reg    <= dq_next;
        drem_reg  <= drem_next;
        dd_reg    <= dd_next;
        dcnt_reg  <= dcnt_next;
        r0_reg    <= r0_next;
        rows_reg  <= rows_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        col_reg   <= col_next;
        count_reg <= count_next;
        base_reg  <= base_next;
        sum_reg   <= sum_next;
        out_reg   <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for box_mean_filter: directed frames, border cases and
// random frames under random idling on both sides. Depends on rtl/bmf_pkg.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // running model of the filter and the queue of means still to come out
    class box_mean_scoreboard;
        int unsigned reg_width;
        int unsigned reg_height;
        int unsigned reg_radius;
        byte unsigned frame_store[bmf_pkg::LineDepth];
        int unsigned in_pos;
        int unsigned out_pos;
        bmf_pkg::out_item_t expected_means[$];
        int errors;
        int results_seen;
        int frames_seen;

        function new();
            reg_width = 640;
            reg_height = 480;
            reg_radius = 1;
            in_pos = 0;
            out_pos = 0;
            errors = 0;
            results_seen = 0;
            frames_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [12:0] value);
            if (idx == bmf_pkg::CFG_IMAGE_WIDTH)
                reg_width = value[10:0];
            else if (idx == bmf_pkg::CFG_IMAGE_HEIGHT)
                reg_height = value;
            else if (idx == bmf_pkg::CFG_WINDOW_RADIUS)
                reg_radius = value[2:0];
        endfunction

        function int unsigned eff_w();
            if (reg_width == 0)
                return 1;
            return (reg_width > bmf_pkg::MaxWidth) ? bmf_pkg::MaxWidth : reg_width;
        endfunction

        function int unsigned eff_h();
            return (reg_height == 0) ? 1 : reg_height;
        endfunction

        function int unsigned eff_r();
            return (reg_radius > bmf_pkg::MaxRadius) ? bmf_pkg::MaxRadius : reg_radius;
        endfunction

        function int unsigned frame_size();
            return eff_w() * eff_h();
        endfunction

        function int unsigned tail_len();
            return eff_r() * eff_w() + eff_r();
        endfunction

        // floor mean over the window clipped to the image
        function logic [7:0] window_mean(int unsigned k, int unsigned w, int unsigned h,
                                         int unsigned r);
            int unsigned row;
            int unsigned col;
            int unsigned row_lo;
            int unsigned row_hi;
            int unsigned col_lo;
            int unsigned col_hi;
            int unsigned total;
            int unsigned cnt;
            row = k / w;
            col = k % w;
            row_lo = (row >= r) ? row - r : 0;
            row_hi = (row + r < h - 1) ? row + r : h - 1;
            col_lo = (col >= r) ? col - r : 0;
            col_hi = (col + r < w - 1) ? col + r : w - 1;
            total = 0;
            for (int unsigned y = row_lo; y <= row_hi; y++)
                for (int unsigned x = col_lo; x <= col_hi; x++)
                    total += frame_store[(y * w + x) % bmf_pkg::LineDepth];
            total &= 16'hFFFF;
            cnt = (row_hi - row_lo + 1) * (col_hi - col_lo + 1);
            return 8'((total / cnt) & 8'hFF);
        endfunction

        function void note_input(bmf_pkg::in_item_t item);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned n;
            int unsigned d;
            bmf_pkg::out_item_t res;
            w = eff_w();
            h = eff_h();
            r = eff_r();
            n = w * h;
            d = r * w + r;
            if (out_pos >= n)
            begin
                in_pos = 0;
                out_pos = 0;
            end
            // early drain is dropped
            if (item.opcode == bmf_pkg::OP_DRAIN && in_pos < n)
                return;
            if (item.opcode == bmf_pkg::OP_PIXEL && in_pos < n)
                frame_store[in_pos % bmf_pkg::LineDepth] = item.pixel;
            if (in_pos < n + d)
                in_pos++;
            if (out_pos + d >= in_pos)
                return;
            res.mean_value = window_mean(out_pos, w, h, r);
            out_pos++;
            res.last_of_frame = (out_pos == n);
            if (res.last_of_frame)
            begin
                in_pos = 0;
                out_pos = 0;
            end
            expected_means.push_back(res);
        endfunction

        function void check_result(bmf_pkg::out_item_t got);
            bmf_pkg::out_item_t want;
            results_seen++;
            if (expected_means.size() == 0)
            begin
                errors++;
                $display("%t: unexpected result mean %0d last %0b", $time,
                         got.mean_value, got.last_of_frame);
                return;
            end
            want = expected_means.pop_front();
            if (got.last_of_frame)
                frames_seen++;
            if (got.mean_value !== want.mean_value)
            begin
                errors++;
                $display("%t: mean_value expected %0d actual %0d", $time,
                         want.mean_value, got.mean_value);
            end
            if (got.last_of_frame !== want.last_of_frame)
            begin
                errors++;
                $display("%t: last_of_frame expected %0b actual %0b", $time,
                         want.last_of_frame, got.last_of_frame);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    bmf_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    bmf_pkg::out_item_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;

    box_mean_scoreboard sb;
    int gap_mode;
    int stall_mode;
    bit hold_req;
    int items_sent;

    box_mean_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #80_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (stall_mode != 0 && $urandom_range(0, 99) < stall_mode * 15)
            begin
                out_stall <= 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                          : $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // result check at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    // one item on the input side, with an optional gap before it
    task automatic send_item(logic op, logic [7:0] pix);
        int gap;
        bmf_pkg::in_item_t item;
        gap = 0;
        if (gap_mode != 0)
        begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(5, 40);
            else if ($urandom_range(0, 3) < gap_mode)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        item.opcode = op;
        item.pixel = pix;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(item);
        items_sent++;
    endtask

    // wait for every result and the block's own tail, then write a register
    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_means.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_frame(int w, int h, int r);
        write_reg(bmf_pkg::CFG_IMAGE_WIDTH, 13'(w));
        write_reg(bmf_pkg::CFG_IMAGE_HEIGHT, 13'(h));
        write_reg(bmf_pkg::CFG_WINDOW_RADIUS, 13'(r));
    endtask

    // one whole frame: pixels with some early drains, then a mixed tail
    task automatic send_frame(int noise_pct);
        send_item(bmf_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
        while (sb.in_pos != 0)
        begin
            if (sb.in_pos < sb.frame_size())
                send_item(($urandom_range(0, 99) < noise_pct) ? bmf_pkg::OP_DRAIN
                                                               : bmf_pkg::OP_PIXEL,
                          8'($urandom_range(0, 255)));
            else
                send_item(($urandom_range(0, 99) < 30) ? bmf_pkg::OP_PIXEL
                                                       : bmf_pkg::OP_DRAIN,
                          8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        sb = new();
        gap_mode = 0;
        stall_mode = 0;
        hold_req = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = bmf_pkg::CFG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 4x3 frame, radius 1, extreme pixels, early drain, surplus pixel
        set_frame(4, 3, 1);
        send_item(bmf_pkg::OP_PIXEL, 8'd255);
        send_item(bmf_pkg::OP_DRAIN, 8'd0);
        for (int k = 1; k < 12; k++)
            send_item(bmf_pkg::OP_PIXEL, (k % 2) ? 8'd0 : 8'd255);
        send_item(bmf_pkg::OP_PIXEL, 8'hAA);
        repeat (4) send_item(bmf_pkg::OP_DRAIN, 8'h55);

        // single pixel frame with its drain tail, and an all-white frame
        set_frame(1, 1, 7);
        send_item(bmf_pkg::OP_PIXEL, 8'd200);
        repeat (14) send_item(bmf_pkg::OP_DRAIN, 8'd0);
        set_frame(2, 2, 0);
        repeat (4) send_item(bmf_pkg::OP_PIXEL, 8'd255);

        // register extremes: clamped width, zero height, narrow frame taller than the window
        gap_mode = 1;
        stall_mode = 1;
        set_frame(2047, 0, 0);
        send_frame(2);
        set_frame(0, 40, 7);
        send_frame(2);

        // long hold-off on the result side while items keep coming
        set_frame(8, 4, 2);
        hold_req = 1'b1;
        send_frame(5);

        // random frames
        while (items_sent < 1450)
        begin
            gap_mode = $urandom_range(0, 3);
            stall_mode = $urandom_range(0, 3);
            set_frame(($urandom_range(0, 7) == 0) ? $urandom_range(17, 32)
                                                  : $urandom_range(0, 16),
                      $urandom_range(0, 6), $urandom_range(0, 7));
            repeat ($urandom_range(1, 2)) send_frame($urandom_range(0, 8));
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_means.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("%0d items sent, %0d results checked over %0d frames", items_sent,
                 sb.results_seen, sb.frames_seen);
        $display("frames from 1x1 up to 1024 wide or 40 tall, radius 0 to 7, %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.expected_means.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
